### rtl/cpc_pkg.sv
// Shared types and constants for the covisibility pair counter.
package cpc_pkg;

   localparam int IDX_W      = 6;
   localparam int CNT_W      = 16;
   localparam int MAX_IMAGES = 2 ** IDX_W;
   localparam int MAX_TRACK  = 32;
   localparam int TRK_AW     = $clog2(MAX_TRACK);
   localparam int LEN_W      = $clog2(MAX_TRACK + 1);
   localparam int CNT_AW     = 2 * IDX_W;
   localparam int CNT_DEPTH  = MAX_IMAGES * MAX_IMAGES;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAIR_RD,
      ST_FWD_WR,
      ST_REV_WR,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [CNT_AW-1:0] wr_addr;
      logic [CNT_W-1:0]  wr_data;
      logic              rd_en;
      logic [CNT_AW-1:0] rd_addr;
   } cnt_req_type;

   typedef struct packed {
      logic              wr_en;
      logic [TRK_AW-1:0] wr_addr;
      logic [IDX_W-1:0]  wr_data;
      logic              rd_en;
      logic [TRK_AW-1:0] rd_addr;
   } trk_req_type;

endpackage

### rtl/cpc_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module cpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cpc_seq.sv
// Sequencer that clears the count store, runs the read-modify-write passes and serves count reads.
module cpc_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [cpc_pkg::IDX_W-1:0]  req_image_index,
   input  logic                       req_last_of_track,
   input  logic [cpc_pkg::IDX_W-1:0]  req_other_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cpc_pkg::CNT_W-1:0]  rsp_pair_count,
   output logic                       rsp_dropped,
   output cpc_pkg::cnt_req_type       cnt_req,
   input  logic [cpc_pkg::CNT_W-1:0]  cnt_rdata,
   output cpc_pkg::trk_req_type       trk_req,
   input  logic [cpc_pkg::IDX_W-1:0]  trk_rdata
);
   import cpc_pkg::*;

   state_type         state_ff, state_in;
   logic              cmd_ff, cmd_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  s_ff, s_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              drop_ff, drop_in;
   logic [CNT_AW-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_drop_ff, rsp_drop_in;
   logic [LEN_W-1:0]  j_next;
   logic [CNT_W-1:0]  cnt_sat;

   assign j_next  = j_ff + LEN_W'(1);
   assign cnt_sat = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      last_ff      <= last_in;
      s_ff         <= s_in;
      j_ff         <= j_in;
      cnt_ff       <= cnt_in;
      drop_ff      <= drop_in;
      rsp_count_ff <= rsp_count_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      s_in         = s_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      clr_in       = clr_ff;
      rsp_count_in = rsp_count_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cnt_req      = '0;
      trk_req      = '0;

      case (state_ff)
         ST_CLEAR: begin
            cnt_req.wr_en   = 1'b1;
            cnt_req.wr_addr = clr_ff;
            clr_in          = clr_ff + CNT_AW'(1);
            if (clr_ff == CNT_AW'(CNT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in  = req_cmd;
               a_in    = req_image_index;
               b_in    = req_other_index;
               last_in = req_last_of_track;
               j_in    = '0;
               cnt_in  = '0;
               drop_in = 1'b0;
               if (req_cmd == CMD_READ) begin
                  cnt_req.rd_en   = 1'b1;
                  cnt_req.rd_addr = {req_image_index, req_other_index};
                  state_in        = ST_READ_WAIT;
               end else if (len_ff == LEN_W'(MAX_TRACK)) begin
                  drop_in  = 1'b1;
                  state_in = ST_FINISH;
               end else if (len_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  trk_req.rd_en   = 1'b1;
                  trk_req.rd_addr = '0;
                  state_in        = ST_PAIR_RD;
               end
            end
         end
         ST_PAIR_RD: begin
            if (trk_rdata != a_ff) begin
               s_in            = trk_rdata;
               cnt_req.rd_en   = 1'b1;
               cnt_req.rd_addr = {a_ff, trk_rdata};
               state_in        = ST_FWD_WR;
            end else begin
               j_in = j_next;
               if (j_next == len_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  trk_req.rd_en   = 1'b1;
                  trk_req.rd_addr = j_next[TRK_AW-1:0];
               end
            end
         end
         ST_FWD_WR: begin
            cnt_req.wr_en   = 1'b1;
            cnt_req.wr_addr = {a_ff, s_ff};
            cnt_req.wr_data = cnt_sat;
            cnt_req.rd_en   = 1'b1;
            cnt_req.rd_addr = {s_ff, a_ff};
            state_in        = ST_REV_WR;
         end
         ST_REV_WR: begin
            cnt_req.wr_en   = 1'b1;
            cnt_req.wr_addr = {s_ff, a_ff};
            cnt_req.wr_data = cnt_sat;
            j_in            = j_next;
            if (j_next == len_ff) begin
               state_in = ST_FINISH;
            end else begin
               trk_req.rd_en   = 1'b1;
               trk_req.rd_addr = j_next[TRK_AW-1:0];
               state_in        = ST_PAIR_RD;
            end
         end
         ST_READ_WAIT: begin
            cnt_in   = cnt_rdata;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               rsp_drop_in  = drop_ff;
               state_in     = ST_IDLE;
               if (cmd_ff == CMD_ADD) begin
                  if (!drop_ff) begin
                     trk_req.wr_en   = 1'b1;
                     trk_req.wr_addr = len_ff[TRK_AW-1:0];
                     trk_req.wr_data = a_ff;
                     len_in          = len_ff + LEN_W'(1);
                  end
                  if (last_ff) begin
                     len_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_count = rsp_count_ff;
   assign rsp_dropped    = rsp_drop_ff;

endmodule

### rtl/covisibility_pair_counter.sv
// Top level of the covisibility pair counter.
//
// The req channel carries one command per beat. An add command (cmd 0)
// appends image_index to the current track and bumps both ordered pair
// counts against every stored element with a different index; last_of_track
// closes the track. A read command (cmd 1) returns the count for the pair
// (image_index, other_index). Every request gives exactly one rsp beat:
// pair_count is zero for adds, and dropped flags an add that found the
// 32-entry track buffer full.
// An add walks the stored elements in order: each stored element that
// differs from the new index costs a track read plus two count
// read-modify-writes, one per ordered pair, on the one count RAM, while an
// equal element costs only its track read. A dropped add and an add onto an
// empty track skip the walk, and a read waits only for the registered count
// read; the next request is accepted in the cycle after the response
// register loads.
// After reset the count store is zeroed in a pass over all 4096 entries, one
// entry per cycle, during which req_ready is low.
// The response is held in an output register; a new request is accepted
// while it waits, and the block stalls only before loading the next one.
module covisibility_pair_counter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [cpc_pkg::IDX_W-1:0]  req_image_index,
   input  logic                       req_last_of_track,
   input  logic [cpc_pkg::IDX_W-1:0]  req_other_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cpc_pkg::CNT_W-1:0]  rsp_pair_count,
   output logic                       rsp_dropped
);
   import cpc_pkg::*;

   cnt_req_type      cnt_req;
   trk_req_type      trk_req;
   logic [CNT_W-1:0] cnt_rdata;
   logic [IDX_W-1:0] trk_rdata;

   cpc_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_image_index   (req_image_index),
      .req_last_of_track (req_last_of_track),
      .req_other_index   (req_other_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pair_count    (rsp_pair_count),
      .rsp_dropped       (rsp_dropped),
      .cnt_req           (cnt_req),
      .cnt_rdata         (cnt_rdata),
      .trk_req           (trk_req),
      .trk_rdata         (trk_rdata)
   );

   cpc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (CNT_DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_req.wr_en),
      .wr_addr (cnt_req.wr_addr),
      .wr_data (cnt_req.wr_data),
      .rd_en   (cnt_req.rd_en),
      .rd_addr (cnt_req.rd_addr),
      .rd_data (cnt_rdata)
   );

   cpc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_TRACK)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (trk_req.wr_en),
      .wr_addr (trk_req.wr_addr),
      .wr_data (trk_req.wr_data),
      .rd_en   (trk_req.rd_en),
      .rd_addr (trk_req.rd_addr),
      .rd_data (trk_rdata)
   );

endmodule

### rtl/cpc_checker.sv
// Port-level assertions for the covisibility pair counter and their binding.
module cpc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [cpc_pkg::CNT_W-1:0]  rsp_pair_count,
   input logic                       rsp_dropped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pair_count) && $stable(rsp_dropped))
      else $error("Stalled response beat changed or vanished.");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_pair_count == '0)
      else $error("Dropped add carried a nonzero count.");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("Request accepted before the count store was cleared.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Back-to-back request accepted while busy.");

endmodule

bind covisibility_pair_counter cpc_checker u_cpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pair_count (rsp_pair_count),
   .rsp_dropped    (rsp_dropped)
);
